@@ rtl/core/csf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_LONG  = 2'd3;

    localparam logic [CNT_W-1:0] CAP_RESET = 4'd6;

endpackage

`default_nettype wire

@@ rtl/core/csf_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// command channel
interface csf_in_if import csf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;

    modport source (output valid, command, in_char, in_last, input ready);
    modport sink   (input valid, command, in_char, in_last, output ready);
endinterface

// result channel
interface csf_out_if import csf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, status, out_char, out_last, entry_count, input ready);
    modport sink   (input valid, status, out_char, out_last, entry_count, output ready);
endinterface

// capacity register write channel
interface csf_cfg_if import csf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

@@ rtl/core/csf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// simple dual port RAM, registered read with read enable
module csf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/circular_string_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Beat payload
// i_in      in   valid/ready    command, in_char, in_last
// o_out     out  valid/ready    status, out_char, out_last, entry_count
// i_cfg     in   valid/ready    capacity (always ready)
//
// Enqueue: one character beat per cycle while o_out is not stalled; only the last one yields a result.
// Dequeue/peek: accept in S_IDLE, read the length memory in S_LEN, then one
// character per cycle out of the character memory in S_SEND while o_out is
// not stalled; the length and character memories both have registered
// reads.
// Reset is synchronous; the memories are not cleared, only pointers and flags.
// Output is a single register: a stalled o_out holds the stream, and a new
// command is taken once the block is idle and the output register is free.
module circular_string_fifo import csf_pkg::*; #(
    parameter int DEPTH     = 8,
    parameter int MAX_CHARS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    csf_in_if.sink    i_in,
    csf_out_if.source o_out,
    csf_cfg_if.sink   i_cfg
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(MAX_CHARS + 1);
    localparam int ADDR_W  = $clog2(DEPTH * MAX_CHARS);
    localparam int CAP_MAX = (DEPTH < 15) ? DEPTH : 15;
    localparam int PW      = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LEN  = 3'b010,
        S_SEND = 3'b100
    } t_state;

    // pointer advance, wrapping at the live capacity
    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] s,
                                                 input logic [CNT_W-1:0]  cap);
        logic [PW-1:0] n;
        n = PW'(s) + PW'(1);
        return (n >= PW'(cap)) ? '0 : n[SLOT_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cap;
    logic [SLOT_W-1:0]  r_head, n_head, r_tail, n_tail;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [LEN_W-1:0]   r_wpos, n_wpos;
    logic               r_open, n_open, r_rej, n_rej, r_ovl, n_ovl;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [LEN_W-1:0]   r_idx, n_idx, r_len, n_len;

    // output register
    logic               r_ovalid;
    logic [STAT_W-1:0]  r_status;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic [CNT_W-1:0]   r_count;

    logic               w_load;
    logic [STAT_W-1:0]  w_ld_status;
    logic [CHAR_W-1:0]  w_ld_char;
    logic               w_ld_last;

    logic               w_in_fire, w_out_free;
    logic [CNT_W-1:0]   w_livecap;
    logic [ADDR_W-1:0]  w_tail_base, w_head_base;
    logic [LEN_W-1:0]   w_len, w_idx_nx;
    logic               e_rej, e_ovl;
    logic [LEN_W-1:0]   e_wpos;

    // memory ports
    logic               cm_we, cm_re;
    logic [ADDR_W-1:0]  cm_waddr, cm_raddr;
    logic [CHAR_W-1:0]  cm_wdata, cm_rdata;
    logic               lm_we, lm_re;
    logic [SLOT_W-1:0]  lm_waddr, lm_raddr;
    logic [LEN_W-1:0]   lm_wdata, lm_rdata;

    csf_ram #(.WIDTH(CHAR_W), .DEPTH(DEPTH * MAX_CHARS)) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    csf_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_re    (lm_re),
        .i_raddr (lm_raddr),
        .o_rdata (lm_rdata)
    );

    // capacity 0 acts as 1, anything above DEPTH acts as DEPTH
    always_comb begin
        if (r_cap == '0) begin
            w_livecap = CNT_W'(1);
        end else if (int'(r_cap) > CAP_MAX) begin
            w_livecap = CNT_W'(CAP_MAX);
        end else begin
            w_livecap = r_cap;
        end
    end

    assign w_out_free  = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign w_tail_base = ADDR_W'(r_tail) * ADDR_W'(MAX_CHARS);
    assign w_head_base = ADDR_W'(r_head) * ADDR_W'(MAX_CHARS);
    assign w_len       = (int'(lm_rdata) > MAX_CHARS) ? LEN_W'(MAX_CHARS) : lm_rdata;
    assign w_idx_nx    = r_idx + LEN_W'(1);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_wpos      = r_wpos;
        n_open      = r_open;
        n_rej       = r_rej;
        n_ovl       = r_ovl;
        n_base      = r_base;
        n_idx       = r_idx;
        n_len       = r_len;
        w_load      = 1'b0;
        w_ld_status = ST_OK;
        w_ld_char   = '0;
        w_ld_last   = 1'b1;
        cm_we       = 1'b0;
        cm_waddr    = w_tail_base;
        cm_wdata    = i_in.in_char;
        cm_re       = 1'b0;
        cm_raddr    = r_base;
        lm_we       = 1'b0;
        lm_waddr    = r_tail;
        lm_wdata    = '0;
        lm_re       = 1'b0;
        lm_raddr    = r_head;
        // first character of a string decides full / not full
        e_rej       = r_open ? r_rej : (r_held >= w_livecap);
        e_wpos      = r_open ? r_wpos : '0;
        e_ovl       = r_open && r_ovl;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_in.command)
                        CMD_ENQ: begin
                            if (!e_rej) begin
                                if (int'(e_wpos) < MAX_CHARS) begin
                                    cm_we    = 1'b1;
                                    cm_waddr = w_tail_base + ADDR_W'(e_wpos);
                                    e_wpos   = e_wpos + LEN_W'(1);
                                end else begin
                                    e_ovl = 1'b1;   // drop, flag too long
                                end
                            end
                            if (i_in.in_last) begin
                                w_load = 1'b1;
                                if (e_rej) begin
                                    w_ld_status = ST_FULL;
                                end else begin
                                    w_ld_status = e_ovl ? ST_LONG : ST_OK;
                                    lm_we       = 1'b1;
                                    lm_wdata    = e_wpos;
                                    n_tail      = f_next(r_tail, w_livecap);
                                    n_held      = r_held + CNT_W'(1);
                                end
                                n_open = 1'b0;
                                n_rej  = 1'b0;
                                n_ovl  = 1'b0;
                                n_wpos = '0;
                            end else begin
                                n_open = 1'b1;
                                n_rej  = e_rej;
                                n_ovl  = e_ovl;
                                n_wpos = e_wpos;
                            end
                        end
                        CMD_DEQ, CMD_PEEK: begin
                            if (r_held == '0) begin
                                w_load      = 1'b1;
                                w_ld_status = ST_EMPTY;
                            end else begin
                                lm_re   = 1'b1;
                                n_base  = w_head_base;
                                n_state = S_LEN;
                                if (i_in.command == CMD_DEQ) begin
                                    n_head = f_next(r_head, w_livecap);
                                    n_held = r_held - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (w_len == '0) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    cm_re    = 1'b1;
                    cm_raddr = r_base;
                    n_idx    = '0;
                    n_len    = w_len;
                    n_state  = S_SEND;
                end
            end
            S_SEND: begin
                // cm_rdata holds character r_idx until it is taken
                if (w_out_free) begin
                    w_load    = 1'b1;
                    w_ld_char = cm_rdata;
                    w_ld_last = (w_idx_nx == r_len);
                    if (w_idx_nx == r_len) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx    = w_idx_nx;
                        cm_re    = 1'b1;
                        cm_raddr = r_base + ADDR_W'(w_idx_nx);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= CAP_RESET;
            r_head   <= '0;
            r_tail   <= '0;
            r_held   <= '0;
            r_wpos   <= '0;
            r_open   <= 1'b0;
            r_rej    <= 1'b0;
            r_ovl    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_held  <= n_held;
            r_wpos  <= n_wpos;
            r_open  <= n_open;
            r_rej   <= n_rej;
            r_ovl   <= n_ovl;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_idx  <= n_idx;
        r_len  <= n_len;
        if (w_load) begin
            r_status <= w_ld_status;
            r_char   <= w_ld_char;
            r_last   <= w_ld_last;
            r_count  <= n_held;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_status;
    assign o_out.out_char    = r_char;
    assign o_out.out_last    = r_last;
    assign o_out.entry_count = r_count;

endmodule

`default_nettype wire
